// File: rtl/core/npcs_pkg.sv
// Package with shared constants, types and helpers of the nearest palette colour search.
`timescale 1ns / 1ps

package npcs_pkg;

    // Palette depth default and fixed field widths.
    localparam int DEFAULT_PALETTE_ENTRIES = 256;
    localparam int CHAN_IN_W               = 10;
    localparam int CHAN_W                  = 8;
    localparam int ENTRY_W                 = 3 * CHAN_W;
    localparam int INDEX_IN_W              = 8;
    localparam int SQ_W                    = 2 * CHAN_W;
    localparam int DIST_W                  = SQ_W + 2;
    localparam int RESULT_W                = 25;
    localparam int MODE_W                  = 3;

    // Channel saturation limit and early-exit distance.
    localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;
    localparam logic [DIST_W-1:0] NEAR_ENOUGH = 18'd8;

    // Opcodes of an input beat.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Screen depth codes.
    localparam logic [MODE_W-1:0] MODE_SEARCH       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RGB565       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RGB888       = 3'd4;
    localparam logic [MODE_W-1:0] PIXEL_BYTES_RESET = MODE_SEARCH;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;
        logic clr_step;
        logic load_query;
        logic scan_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_issued_all;
        logic scan_done;
        logic out_free;
        logic search_mode;
    } status_t;

    // Clamp a 10-bit channel to 8 bits.
    function automatic logic [CHAN_W-1:0] sat_chan(input logic [CHAN_IN_W-1:0] v);
        logic [CHAN_W-1:0] res;
        if (v > CHAN_IN_W'(CHAN_MAX))
        begin
            res = CHAN_MAX;
        end
        else
        begin
            res = v[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/npcs_item_if.sv
// Interface for the input channel: palette writes and colour queries.
`timescale 1ns / 1ps

interface npcs_item_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic [npcs_pkg::INDEX_IN_W-1:0]    entry_index;
    logic [npcs_pkg::CHAN_IN_W-1:0]     red;
    logic [npcs_pkg::CHAN_IN_W-1:0]     green;
    logic [npcs_pkg::CHAN_IN_W-1:0]     blue;

    modport source (output valid, opcode, entry_index, red, green, blue, input ready);
    modport sink   (input valid, opcode, entry_index, red, green, blue, output ready);
endinterface

// File: rtl/core/npcs_result_if.sv
// Interface for the result channel carrying match values.
`timescale 1ns / 1ps

interface npcs_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [npcs_pkg::RESULT_W-1:0]   match_value;

    modport source (output valid, match_value, input ready);
    modport sink   (input valid, match_value, output ready);
endinterface

// File: rtl/core/npcs_ctrl.sv
// Controller state machine: clearing pass, beat acceptance, palette scan and result hand-off.
`timescale 1ns / 1ps

module npcs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_opcode,
    output logic                item_ready,
    input  npcs_pkg::status_t   stat,
    output npcs_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_opcode == npcs_pkg::OP_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = stat.search_mode ? ST_SCAN : ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = !stat.scan_issued_all && !stat.scan_done;
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/npcs_datapath.sv
// Datapath: palette memory, depth register, distance pipeline, best tracker and output register.
`timescale 1ns / 1ps

module npcs_datapath #(
    parameter int PALETTE_ENTRIES = npcs_pkg::DEFAULT_PALETTE_ENTRIES
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  npcs_pkg::cmd_t                          cmd,
    output npcs_pkg::status_t                       stat,
    input  logic                                    cfg_we,
    input  logic [npcs_pkg::MODE_W-1:0]             cfg_data,
    input  logic [npcs_pkg::INDEX_IN_W-1:0]         entry_index,
    input  logic [npcs_pkg::CHAN_IN_W-1:0]          red,
    input  logic [npcs_pkg::CHAN_IN_W-1:0]          green,
    input  logic [npcs_pkg::CHAN_IN_W-1:0]          blue,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [npcs_pkg::RESULT_W-1:0]    out_value
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    localparam int CW = npcs_pkg::CHAN_W;
    localparam int DW = npcs_pkg::DIST_W;
    localparam int SW = npcs_pkg::SQ_W;
    localparam int RW = npcs_pkg::RESULT_W;

    logic [npcs_pkg::ENTRY_W-1:0] mem [PALETTE_ENTRIES];

    logic [CW-1:0] sat_r, sat_g, sat_b;
    logic          wr_in_range;
    logic          mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [npcs_pkg::ENTRY_W-1:0] mem_wdata;

    logic [npcs_pkg::MODE_W-1:0] mode_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [CW-1:0]    q_r_reg, q_g_reg, q_b_reg;
    logic [IDX_W-1:0] scan_addr_reg;
    logic             issued_all_reg;

    logic                         rd_valid_reg;
    logic [IDX_W-1:0]             rd_idx_reg;
    logic [npcs_pkg::ENTRY_W-1:0] rd_data_reg;

    logic             sq_valid_reg;
    logic [IDX_W-1:0] sq_idx_reg;
    logic [SW-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;

    logic [DW-1:0]    best_reg;
    logic [IDX_W-1:0] found_reg;
    logic             hit_reg;
    logic             end_reg;

    logic             out_valid_reg;
    logic [RW-1:0]    out_data_reg;

    logic [CW-1:0] d_r, d_g, d_b;
    logic [DW-1:0] dist_sum;
    logic          better;
    logic [RW-1:0] result;

    // Saturate the incoming channels.
    assign sat_r = npcs_pkg::sat_chan(red);
    assign sat_g = npcs_pkg::sat_chan(green);
    assign sat_b = npcs_pkg::sat_chan(blue);

    // Single write port, shared by the clearing pass and write beats.
    assign wr_in_range = (32'(entry_index) < PALETTE_ENTRIES);
    assign mem_we      = cmd.clr_step || (cmd.wr_en && wr_in_range);
    assign mem_waddr   = cmd.clr_step ? clr_cnt_reg : IDX_W'(entry_index);
    assign mem_wdata   = cmd.clr_step ? '0 : {sat_r, sat_g, sat_b};

    // Palette memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[scan_addr_reg];
            rd_idx_reg  <= scan_addr_reg;
        end
    end

    // Absolute channel differences of the entry just read.
    assign d_r = (rd_data_reg[23:16] > q_r_reg) ? rd_data_reg[23:16] - q_r_reg
                                                : q_r_reg - rd_data_reg[23:16];
    assign d_g = (rd_data_reg[15:8] > q_g_reg) ? rd_data_reg[15:8] - q_g_reg
                                               : q_g_reg - rd_data_reg[15:8];
    assign d_b = (rd_data_reg[7:0] > q_b_reg) ? rd_data_reg[7:0] - q_b_reg
                                              : q_b_reg - rd_data_reg[7:0];

    // Squares registered, then summed and compared against the best so far.
    always_ff @(posedge clk)
    begin
        sq_r_reg   <= d_r * d_r;
        sq_g_reg   <= d_g * d_g;
        sq_b_reg   <= d_b * d_b;
        sq_idx_reg <= rd_idx_reg;
    end

    assign dist_sum = DW'(sq_r_reg) + DW'(sq_g_reg) + DW'(sq_b_reg);
    assign better   = sq_valid_reg && !hit_reg && (dist_sum < best_reg);

    // Query capture, scan progress and best tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= npcs_pkg::PIXEL_BYTES_RESET;
            clr_cnt_reg    <= '0;
            scan_addr_reg  <= '0;
            issued_all_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            sq_valid_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            end_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.load_query)
            begin
                scan_addr_reg  <= '0;
                issued_all_reg <= 1'b0;
                rd_valid_reg   <= 1'b0;
                sq_valid_reg   <= 1'b0;
                hit_reg        <= 1'b0;
                end_reg        <= 1'b0;
            end
            else
            begin
                rd_valid_reg <= cmd.scan_step;
                sq_valid_reg <= rd_valid_reg;
                if (cmd.scan_step)
                begin
                    scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                    if (scan_addr_reg == LAST_IDX)
                    begin
                        issued_all_reg <= 1'b1;
                    end
                end
                if (better && (dist_sum < npcs_pkg::NEAR_ENOUGH))
                begin
                    hit_reg <= 1'b1;
                end
                if (sq_valid_reg && (sq_idx_reg == LAST_IDX))
                begin
                    end_reg <= 1'b1;
                end
            end
        end
    end

    // Query channels and best distance are payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_r_reg   <= sat_r;
            q_g_reg   <= sat_g;
            q_b_reg   <= sat_b;
            best_reg  <= '1;
            found_reg <= '0;
        end
        else if (better)
        begin
            best_reg  <= dist_sum;
            found_reg <= sq_idx_reg;
        end
    end

    // Result selection by screen depth.
    always_comb
    begin
        case (mode_reg)
            npcs_pkg::MODE_SEARCH: result = RW'(found_reg);
            npcs_pkg::MODE_RGB565: result = RW'({q_r_reg[7:3], q_g_reg[7:2], q_b_reg[7:3]});
            npcs_pkg::MODE_RGB888: result = RW'({q_r_reg, q_g_reg, q_b_reg});
            default:               result = '1;
        endcase
    end

    // Output register holds a result beat until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = $signed(out_data_reg);

    // Status back to the controller.
    assign stat.clr_last        = (clr_cnt_reg == LAST_IDX);
    assign stat.scan_issued_all = issued_all_reg;
    assign stat.scan_done       = hit_reg || end_reg;
    assign stat.out_free        = !out_valid_reg || out_ready;
    assign stat.search_mode     = (mode_reg == npcs_pkg::MODE_SEARCH);

endmodule

// File: rtl/core/nearest_palette_colour_search.sv
// Top level of the nearest palette colour search: controller, datapath and checks.
`timescale 1ns / 1ps

// Channel   Role    Beat contents
// item      sink    opcode, entry_index, red, green, blue
// result    source  match_value (25-bit signed)
// cfg       write   cfg_we, cfg_data = pixel_bytes
//
// A palette write goes into the memory as its beat is taken. A query in RGB565, RGB888 or
// unsupported mode captures its channels and then loads the output register. A palette search issues one
// memory read per cycle through a three-stage read, square and compare pipeline,
// and a close match ends the scan early.
// After reset every palette entry is cleared to black before
// the first beat is taken. A stalled result holds the block before its next beat.

module nearest_palette_colour_search #(
    parameter int PALETTE_ENTRIES = npcs_pkg::DEFAULT_PALETTE_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    npcs_item_if.sink                   item,
    npcs_result_if.source               result,
    input  logic                        cfg_we,
    input  logic [npcs_pkg::MODE_W-1:0] cfg_data
);

    npcs_pkg::cmd_t    cmd;
    npcs_pkg::status_t stat;

    // Sequencer.
    npcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_opcode (item.opcode),
        .item_ready  (item.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Memory, distance pipeline and output register.
    npcs_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .entry_index (item.entry_index),
        .red         (item.red),
        .green       (item.green),
        .blue        (item.blue),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_value   (result.match_value)
    );

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending beat");

    // The scan never reads past the last palette entry.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !stat.scan_issued_all)
        else $error("scan read past the last entry");

    // Once a query beat is taken, the block is busy on the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.opcode == npcs_pkg::OP_QUERY) |=> !item.ready)
        else $error("new beat taken while a query is in flight");

    // No beat is taken during the clearing pass.
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !item.ready)
        else $error("beat taken during the clearing pass");

endmodule
